// ===== hdl/ple_pkg.sv =====
// Package for the positional list engine: action and status codes, field
// widths, default parameter values and the result record type.
// No dependencies.
package ple_pkg;

    // Field widths of the two channels.
    localparam int ACTION_W = 2;
    localparam int ITEM_W   = 32;
    localparam int POS_W    = 7;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    // Defaults for the top-level parameters.
    localparam int DEF_CAPACITY   = 64;
    localparam int DEF_DATA_WIDTH = 32;

    // Action codes.
    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ   = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

    // One result record from the sequencer to the output register.
    typedef struct packed {
        logic                valid;
        logic [STATUS_W-1:0] status;
        logic [ITEM_W-1:0]   value;
        logic [COUNT_W-1:0]  count;
        logic                last;
    } ple_res_t;

endpackage

// ===== hdl/ple_store_ram.sv =====
// Element store of the positional list engine: a simple dual-port RAM
// with one write port and one registered read port. Depends on nothing.
module ple_store_ram #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = 6
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/ple_seq.sv =====
// Sequencer of the positional list engine: takes input transfers, checks
// positions, runs the shift and read-out passes through the element store
// and hands result records to the output register. Uses ple_pkg.
module ple_seq
    import ple_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH,
    parameter int ADDR_W     = $clog2(CAPACITY),
    parameter int CNT_W      = $clog2(CAPACITY + 1)
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // Input channel.
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [ACTION_W-1:0]      s_action,
    input  logic signed [ITEM_W-1:0] s_item_value,
    input  logic [POS_W-1:0]         s_position,
    // Output register can take a record in this cycle.
    input  logic                     out_free,
    output ple_res_t                 res,
    // Element store ports.
    output logic                     ram_we,
    output logic [ADDR_W-1:0]        ram_waddr,
    output logic [DATA_WIDTH-1:0]    ram_wdata,
    output logic                     ram_re,
    output logic [ADDR_W-1:0]        ram_raddr,
    input  logic [DATA_WIDTH-1:0]    ram_rdata
);

    localparam int EXT_W = (DATA_WIDTH > ITEM_W) ? DATA_WIDTH : ITEM_W;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DECODE   = 3'd1;
    localparam logic [2:0] S_SHIFT    = 3'd2;
    localparam logic [2:0] S_RESP     = 3'd3;
    localparam logic [2:0] S_RD_ISSUE = 3'd4;
    localparam logic [2:0] S_RD_DATA  = 3'd5;

    logic [2:0]            state_reg,   state_next;
    logic [ACTION_W-1:0]   act_reg,     act_next;
    logic [DATA_WIDTH-1:0] val_reg,     val_next;
    logic [POS_W-1:0]      pos_reg,     pos_next;
    logic [ADDR_W-1:0]     pidx_reg,    pidx_next;
    logic [CNT_W-1:0]      count_reg,   count_next;
    logic [CNT_W-1:0]      rem_reg,     rem_next;
    logic [ADDR_W-1:0]     rd_addr_reg, rd_addr_next;
    logic [ADDR_W-1:0]     wr_addr_reg, wr_addr_next;
    logic                  pend_reg,    pend_next;
    logic [STATUS_W-1:0]   status_reg,  status_next;

    logic [EXT_W-1:0]  in_ext;
    logic [EXT_W-1:0]  rd_ext;
    logic [ADDR_W-1:0] p_idx;
    logic [POS_W:0]    pos_wide;
    logic [POS_W:0]    cnt_wide;
    logic              shift_up;
    logic              issue;
    logic              rd_last;

    // Sign-extend on the way in and on the way out of the store.
    assign in_ext = EXT_W'(s_item_value);
    assign rd_ext = EXT_W'($signed(ram_rdata));

    assign p_idx    = ADDR_W'(pos_reg - POS_W'(1));
    assign pos_wide = {1'b0, pos_reg};
    assign cnt_wide = (POS_W + 1)'(count_reg);
    assign shift_up = (act_reg == ACT_DELETE);
    assign issue    = (rem_reg != '0);
    assign rd_last  = ((CNT_W'(rd_addr_reg) + CNT_W'(1)) == count_reg);

    assign s_ready = (state_reg == S_IDLE);

    // Next-state logic of the sequencer.
    always_comb begin
        state_next   = state_reg;
        act_next     = act_reg;
        val_next     = val_reg;
        pos_next     = pos_reg;
        pidx_next    = pidx_reg;
        count_next   = count_reg;
        rem_next     = rem_reg;
        rd_addr_next = rd_addr_reg;
        wr_addr_next = wr_addr_reg;
        pend_next    = pend_reg;
        status_next  = status_reg;

        ram_we    = 1'b0;
        ram_waddr = wr_addr_reg;
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;
        ram_raddr = rd_addr_reg;

        res.valid  = 1'b0;
        res.status = status_reg;
        res.value  = '0;
        res.count  = COUNT_W'(count_reg);
        res.last   = 1'b1;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    act_next   = s_action;
                    val_next   = in_ext[DATA_WIDTH-1:0];
                    pos_next   = s_position;
                    state_next = S_DECODE;
                end
            end

            S_DECODE: begin
                pidx_next   = p_idx;
                pend_next   = 1'b0;
                status_next = ST_OK;
                state_next  = S_RESP;
                case (act_reg)
                    ACT_INSERT: begin
                        if (pos_reg == '0 || pos_wide > cnt_wide + (POS_W + 1)'(1)) begin
                            status_next = ST_BADPOS;
                        end else if (count_reg == CNT_W'(CAPACITY)) begin
                            status_next = ST_FULL;
                        end else begin
                            // Move entries count-1 down to p up by one place.
                            rem_next     = count_reg - CNT_W'(p_idx);
                            rd_addr_next = ADDR_W'(count_reg - CNT_W'(1));
                            wr_addr_next = ADDR_W'(count_reg);
                            state_next   = S_SHIFT;
                        end
                    end
                    ACT_DELETE: begin
                        if (pos_reg == '0 || pos_wide > cnt_wide) begin
                            status_next = ST_BADPOS;
                        end else begin
                            // Move entries p+1 up to count-1 down by one place.
                            rem_next     = count_reg - CNT_W'(p_idx) - CNT_W'(1);
                            rd_addr_next = p_idx + ADDR_W'(1);
                            wr_addr_next = p_idx;
                            state_next   = S_SHIFT;
                        end
                    end
                    ACT_READ: begin
                        if (count_reg != '0) begin
                            rd_addr_next = '0;
                            state_next   = S_RD_ISSUE;
                        end
                    end
                    default: begin
                        status_next = ST_OK;
                    end
                endcase
            end

            S_SHIFT: begin
                // Read one entry ahead, write the entry read last cycle.
                if (issue) begin
                    ram_re       = 1'b1;
                    ram_raddr    = rd_addr_reg;
                    rd_addr_next = shift_up ? rd_addr_reg + ADDR_W'(1)
                                            : rd_addr_reg - ADDR_W'(1);
                    rem_next     = rem_reg - CNT_W'(1);
                end
                if (pend_reg) begin
                    ram_we       = 1'b1;
                    ram_waddr    = wr_addr_reg;
                    ram_wdata    = ram_rdata;
                    wr_addr_next = shift_up ? wr_addr_reg + ADDR_W'(1)
                                            : wr_addr_reg - ADDR_W'(1);
                end
                pend_next = issue;
                // Pass done: place the new value or drop the last entry.
                if (!issue && !pend_reg) begin
                    if (shift_up) begin
                        count_next = count_reg - CNT_W'(1);
                    end else begin
                        ram_we     = 1'b1;
                        ram_waddr  = pidx_reg;
                        ram_wdata  = val_reg;
                        count_next = count_reg + CNT_W'(1);
                    end
                    state_next = S_RESP;
                end
            end

            S_RESP: begin
                res.valid = out_free;
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end

            S_RD_ISSUE: begin
                // Only read once the output register is sure to be empty.
                if (out_free) begin
                    ram_re     = 1'b1;
                    ram_raddr  = rd_addr_reg;
                    state_next = S_RD_DATA;
                end
            end

            S_RD_DATA: begin
                res.valid    = 1'b1;
                res.status   = ST_OK;
                res.value    = rd_ext[ITEM_W-1:0];
                res.last     = rd_last;
                rd_addr_next = rd_addr_reg + ADDR_W'(1);
                state_next   = rd_last ? S_IDLE : S_RD_ISSUE;
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
            rem_reg   <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            rem_reg   <= rem_next;
        end
    end

    // Working registers of the current item.
    always_ff @(posedge aclk) begin
        act_reg     <= act_next;
        val_reg     <= val_next;
        pos_reg     <= pos_next;
        pidx_reg    <= pidx_next;
        rd_addr_reg <= rd_addr_next;
        wr_addr_reg <= wr_addr_next;
        status_reg  <= status_next;
    end

endmodule

// ===== hdl/positional_list_engine_core.sv =====
// Top level of the positional list engine: sequencer, element store and
// the result output register. Uses ple_pkg, ple_seq and ple_store_ram.
//
// The engine keeps an ordered list of up to CAPACITY values in one RAM
// with a registered read port, and handles one input transfer at a time.
// Insert and delete move every entry behind the position by one place,
// one RAM read and one write per cycle. A read-out returns one result
// transfer per element, as each element is read from the RAM only once
// the output register is free. An empty list, a rejected position, a full
// list and an unused action code give a single result. A stalled result
// channel holds up the results and with them the next input transfer.
// The RAM holds no reset value; only entries below the current count are
// ever read.
module positional_list_engine_core
    import ple_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // Input channel.
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [ACTION_W-1:0]       s_action,
    input  logic signed [ITEM_W-1:0]  s_item_value,
    input  logic [POS_W-1:0]          s_position,
    // Result channel.
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [STATUS_W-1:0]       m_status,
    output logic signed [ITEM_W-1:0]  m_read_value,
    output logic [COUNT_W-1:0]        m_element_count,
    output logic                      m_last_of_run
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    ple_res_t              res;
    logic                  out_free;
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic                  ram_re;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;

    logic                m_valid_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [ITEM_W-1:0]   m_value_reg;
    logic [COUNT_W-1:0]  m_count_reg;
    logic                m_last_reg;

    // The output register can load when empty or when its transfer completes.
    assign out_free = !m_valid_reg || m_ready;

    ple_seq #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH),
        .ADDR_W     (ADDR_W),
        .CNT_W      (CNT_W)
    ) u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_item_value (s_item_value),
        .s_position   (s_position),
        .out_free     (out_free),
        .res          (res),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .ram_re       (ram_re),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata)
    );

    ple_store_ram #(
        .DEPTH  (CAPACITY),
        .WIDTH  (DATA_WIDTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Output valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res.valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output payload, loaded with each new result record.
    always_ff @(posedge aclk) begin
        if (res.valid) begin
            m_status_reg <= res.status;
            m_value_reg  <= res.value;
            m_count_reg  <= res.count;
            m_last_reg   <= res.last;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_read_value    = m_value_reg;
    assign m_element_count = m_count_reg;
    assign m_last_of_run   = m_last_reg;

endmodule
